/* rtl/hpm_pkg.sv */
package hpm_pkg;

   // fixed field widths
   localparam int unsigned PAGE_ID_W     = 12;
   localparam int unsigned COUNTER_W     = 8;
   localparam int unsigned THRESHOLD_W   = 8;
   localparam int unsigned INTERVAL_W    = 16;
   localparam int unsigned TALLY_W       = 32;

   // bus widths
   localparam int unsigned REQ_TDATA_W   = 16;
   localparam int unsigned RSP_TDATA_W   = 80;
   localparam int unsigned CSR_INDEX_W   = 4;
   localparam int unsigned CSR_DATA_W    = 16;

   // default geometry
   localparam int unsigned NUM_PAGES_DEFAULT = 4096;
   localparam int unsigned NUM_SETS_DEFAULT  = 1024;

   localparam logic [COUNTER_W-1:0]   COUNTER_MAX    = 8'd255;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST  = 8'd16;
   localparam logic [INTERVAL_W-1:0]  INTERVAL_RST   = 16'd1000;

   // entries between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOT_THRESHOLD  = 4'd0,
      CSR_DECAY_INTERVAL = 4'd1
   } csr_index_type;

   // address width of a store of n entries
   function automatic int unsigned idx_width(input int unsigned n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // remainder by an elaboration constant, restoring compare and subtract
   function automatic logic [PAGE_ID_W-1:0] mod_const(
      input logic [PAGE_ID_W-1:0] value,
      input int unsigned          divisor
   );
      logic [PAGE_ID_W-1:0] rem;
      logic [63:0]          step;
      rem = value;
      for (int k = PAGE_ID_W - 1; k >= 0; k--) begin
         step = 64'(divisor) << k;
         if (step <= 64'(rem)) begin
            rem = rem - PAGE_ID_W'(step);
         end
      end
      return rem;
   endfunction

endpackage

/* rtl/hpm_front.sv */
module hpm_front #(
   parameter int unsigned NUM_PAGES = hpm_pkg::NUM_PAGES_DEFAULT,
   parameter int unsigned NUM_SETS  = hpm_pkg::NUM_SETS_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              init_busy,
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   input  logic [hpm_pkg::REQ_TDATA_W-1:0]                   req_tdata,
   input  logic                                              req_tlast,
   output logic                                              q_valid,
   input  logic                                              q_ready,
   output logic [hpm_pkg::idx_width(NUM_PAGES)-1:0]          q_page,
   output logic [hpm_pkg::idx_width(NUM_SETS)-1:0]           q_set,
   output logic                                              q_last
);
   import hpm_pkg::*;

   localparam int unsigned PW = idx_width(NUM_PAGES);
   localparam int unsigned SW = idx_width(NUM_SETS);

   logic          fr_valid_ff, fr_valid_in;
   logic [PW-1:0] fr_page_ff, fr_page_in;
   logic          fr_last_ff, fr_last_in;
   logic          accept;
   logic          push;

   assign req_tready = !init_busy && (!fr_valid_ff || q_ready);
   assign accept     = req_tvalid && req_tready;
   assign push       = fr_valid_ff && q_ready;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      fr_page_in  = fr_page_ff;
      fr_last_in  = fr_last_ff;
      if (push) begin
         fr_valid_in = 1'b0;
      end
      if (accept) begin
         fr_valid_in = 1'b1;
         // fold out-of-range page numbers onto the page space
         fr_page_in  = PW'(mod_const(req_tdata[PAGE_ID_W-1:0], NUM_PAGES));
         fr_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      fr_page_ff <= fr_page_in;
      fr_last_ff <= fr_last_in;
   end

   // direct-mapped set of the folded page
   assign q_valid = fr_valid_ff;
   assign q_page  = fr_page_ff;
   assign q_set   = SW'(mod_const(PAGE_ID_W'(fr_page_ff), NUM_SETS));
   assign q_last  = fr_last_ff;

endmodule

/* rtl/hpm_queue.sv */
module hpm_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = hpm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import hpm_pkg::*;

   localparam int unsigned AW = idx_width(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/hpm_engine.sv */
module hpm_engine #(
   parameter int unsigned NUM_PAGES = hpm_pkg::NUM_PAGES_DEFAULT,
   parameter int unsigned NUM_SETS  = hpm_pkg::NUM_SETS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   output logic                                     init_busy,
   input  logic                                     q_valid,
   output logic                                     q_pop,
   input  logic [hpm_pkg::idx_width(NUM_PAGES)-1:0] q_page,
   input  logic [hpm_pkg::idx_width(NUM_SETS)-1:0]  q_set,
   input  logic                                     q_last,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [hpm_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [hpm_pkg::CSR_DATA_W-1:0]           csr_data,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [hpm_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tlast
);
   import hpm_pkg::*;

   localparam int unsigned PW   = idx_width(NUM_PAGES);
   localparam int unsigned SW   = idx_width(NUM_SETS);
   localparam int unsigned RW   = (PW > SW) ? PW : SW;
   localparam int unsigned MAXD = (NUM_PAGES > NUM_SETS) ? NUM_PAGES : NUM_SETS;
   localparam int unsigned XW   = $clog2(MAXD + 1);
   localparam int unsigned MW   = COUNTER_W + 1;

   typedef enum logic [3:0] {
      ST_INIT   = 4'b0001,
      ST_FETCH  = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_SWEEP  = 4'b1000
   } state_type;

   // page metadata: hot mark over access counter
   logic [MW-1:0] meta_mem [NUM_PAGES];
   logic [RW-1:0] res_mem  [NUM_SETS];

   state_type        state_ff, state_in;
   logic [XW-1:0]    idx_ff, idx_in;
   logic [MW-1:0]    meta_rd_ff;
   logic [RW-1:0]    res_rd_ff;
   logic             meta_re, res_re;
   logic [PW-1:0]    meta_raddr;
   logic [SW-1:0]    res_raddr;
   logic             meta_we, res_we;
   logic [PW-1:0]    meta_waddr;
   logic [SW-1:0]    res_waddr;
   logic [MW-1:0]    meta_wdata;
   logic [RW-1:0]    res_wdata;
   logic [PW-1:0]    cur_page_ff, cur_page_in;
   logic [SW-1:0]    cur_set_ff, cur_set_in;
   logic             cur_last_ff, cur_last_in;
   logic [THRESHOLD_W-1:0] thr_ff, thr_in;
   logic [INTERVAL_W-1:0]  ivl_ff, ivl_in;
   logic [THRESHOLD_W-1:0] sweep_thr_ff, sweep_thr_in;
   logic [INTERVAL_W-1:0]  interval_ff, interval_in;
   logic [TALLY_W-1:0]     hit_tally_ff, hit_tally_in;
   logic [TALLY_W-1:0]     miss_tally_ff, miss_tally_in;
   logic             sw_wv_ff, sw_wv_in;
   logic [PW-1:0]    sw_wa_ff, sw_wa_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [COUNTER_W-1:0]   cnt_old, cnt_new, cnt_half;
   logic                   hot_new, hit, migrate, go;
   logic [INTERVAL_W-1:0]  limit;
   logic [INTERVAL_W:0]    interval_next;
   logic                   decay_hit;
   logic [PAGE_ID_W-1:0]   evicted;
   logic [TALLY_W-1:0]     hit_tally_next, miss_tally_next;

   assign init_busy  = (state_ff == ST_INIT);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // update arithmetic on the fetched entry
   always_comb begin
      cnt_old         = meta_rd_ff[COUNTER_W-1:0];
      cnt_new         = (cnt_old == COUNTER_MAX) ? cnt_old : cnt_old + COUNTER_W'(1);
      hot_new         = meta_rd_ff[COUNTER_W] || (cnt_new >= thr_ff);
      hit             = (res_rd_ff == RW'(cur_page_ff));
      migrate         = hot_new && !hit;
      evicted         = migrate ? PAGE_ID_W'(res_rd_ff) : '0;
      limit           = (ivl_ff == '0) ? INTERVAL_W'(1) : ivl_ff;
      interval_next   = {1'b0, interval_ff} + (INTERVAL_W + 1)'(1);
      decay_hit       = (interval_next >= {1'b0, limit});
      hit_tally_next  = hit ? hit_tally_ff + TALLY_W'(1) : hit_tally_ff;
      miss_tally_next = hit ? miss_tally_ff : miss_tally_ff + TALLY_W'(1);
      go              = !rsp_valid_ff || rsp_tready;
      cnt_half        = meta_rd_ff[COUNTER_W-1:0] >> 1;
   end

   // configuration writes, unknown indexes dropped
   always_comb begin
      thr_in = thr_ff;
      ivl_in = ivl_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HOT_THRESHOLD:  thr_in = csr_data[THRESHOLD_W-1:0];
            CSR_DECAY_INTERVAL: ivl_in = csr_data[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      q_pop         = 1'b0;
      meta_re       = 1'b0;
      meta_raddr    = q_page;
      res_re        = 1'b0;
      res_raddr     = q_set;
      meta_we       = 1'b0;
      meta_waddr    = idx_ff[PW-1:0];
      meta_wdata    = '0;
      res_we        = 1'b0;
      res_waddr     = idx_ff[SW-1:0];
      res_wdata     = RW'(idx_ff);
      cur_page_in   = cur_page_ff;
      cur_set_in    = cur_set_ff;
      cur_last_in   = cur_last_ff;
      sweep_thr_in  = sweep_thr_ff;
      interval_in   = interval_ff;
      hit_tally_in  = hit_tally_ff;
      miss_tally_in = miss_tally_ff;
      sw_wv_in      = 1'b0;
      sw_wa_in      = idx_ff[PW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_INIT: begin
            // clearing pass: counters to zero, set i holds page i
            meta_we = (idx_ff < XW'(NUM_PAGES));
            res_we  = (idx_ff < XW'(NUM_SETS));
            if (idx_ff == XW'(MAXD - 1)) begin
               state_in = ST_FETCH;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + XW'(1);
            end
         end
         ST_FETCH: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               meta_re     = 1'b1;
               res_re      = 1'b1;
               cur_page_in = q_page;
               cur_set_in  = q_set;
               cur_last_in = q_last;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (go) begin
               meta_we       = 1'b1;
               meta_waddr    = cur_page_ff;
               meta_wdata    = {hot_new, cnt_new};
               res_we        = migrate;
               res_waddr     = cur_set_ff;
               res_wdata     = RW'(cur_page_ff);
               hit_tally_in  = hit_tally_next;
               miss_tally_in = miss_tally_next;
               interval_in   = decay_hit ? '0 : interval_next[INTERVAL_W-1:0];
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {1'b0, miss_tally_next, hit_tally_next, decay_hit,
                                evicted, migrate, hit};
               rsp_last_in   = cur_last_ff;
               if (decay_hit) begin
                  state_in     = ST_SWEEP;
                  sweep_thr_in = thr_ff;
                  idx_in       = '0;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SWEEP: begin
            // read entry idx while entry idx-1 is written back halved
            meta_re    = (idx_ff < XW'(NUM_PAGES));
            meta_raddr = idx_ff[PW-1:0];
            sw_wv_in   = (idx_ff < XW'(NUM_PAGES));
            sw_wa_in   = idx_ff[PW-1:0];
            meta_we    = sw_wv_ff;
            meta_waddr = sw_wa_ff;
            meta_wdata = {meta_rd_ff[COUNTER_W] && !(cnt_half < sweep_thr_ff), cnt_half};
            if (idx_ff == XW'(NUM_PAGES)) begin
               state_in = ST_FETCH;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + XW'(1);
            end
         end
         default: begin
            state_in = ST_INIT;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (meta_re) begin
         meta_rd_ff <= meta_mem[meta_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      if (res_re) begin
         res_rd_ff <= res_mem[res_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         idx_ff        <= '0;
         thr_ff        <= THRESHOLD_RST;
         ivl_ff        <= INTERVAL_RST;
         interval_ff   <= '0;
         hit_tally_ff  <= '0;
         miss_tally_ff <= '0;
         sw_wv_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         thr_ff        <= thr_in;
         ivl_ff        <= ivl_in;
         interval_ff   <= interval_in;
         hit_tally_ff  <= hit_tally_in;
         miss_tally_ff <= miss_tally_in;
         sw_wv_ff      <= sw_wv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_page_ff  <= cur_page_in;
      cur_set_ff   <= cur_set_in;
      cur_last_ff  <= cur_last_in;
      sweep_thr_ff <= sweep_thr_in;
      sw_wa_ff     <= sw_wa_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

/* rtl/hot_page_migration_direct_mapped.sv */
// hot page migration, direct-mapped fast memory with counter decay
//
// req channel: one beat per page request; the page number sits in the low
// bits of req_tdata, req_tlast marks the last request of a trace
// rsp channel: exactly one beat per request, in request order; rsp_tlast
// echoes req_tlast of that request
// csr channel: index 0 hot threshold, index 1 decay interval; csr_ready is
// always high, writes to other indexes are dropped
//
// the engine takes one request at a time: a fetch state reads the page metadata
// and the set resident, and an update state writes them back once the output
// register is free; after every request that closes a decay interval, the
// halving sweep walks the metadata memory one entry a cycle
// request path: classifier register, queue, then the fetch and update states
// reset: a clearing pass zeroes the counters and loads set i with page i;
// req_tready stays low until it ends
// stall: results wait in the output register; a short queue between the
// classifier and the update engine keeps accepting until it fills
module hot_page_migration_direct_mapped #(
   parameter int unsigned NUM_PAGES = hpm_pkg::NUM_PAGES_DEFAULT,
   parameter int unsigned NUM_SETS  = hpm_pkg::NUM_SETS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request beat
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hpm_pkg::REQ_TDATA_W-1:0] req_tdata,   // page[11:0], zero pad
   input  logic                            req_tlast,   // trace_last
   // result beat
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hpm_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // hit_fast, migrated,
                                                        // evicted_page[11:0], decayed,
                                                        // fast_total[31:0],
                                                        // slow_total[31:0], zero pad
   output logic                            rsp_tlast,   // trace_end
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hpm_pkg::*;

   localparam int unsigned PW = idx_width(NUM_PAGES);
   localparam int unsigned SW = idx_width(NUM_SETS);
   localparam int unsigned QW = PW + SW + 1;

   logic          init_busy;
   logic          fq_valid, fq_ready;
   logic [PW-1:0] fq_page;
   logic [SW-1:0] fq_set;
   logic          fq_last;
   logic          qe_valid, qe_pop;
   logic [QW-1:0] qe_data;

   // classifier: folds the page and picks its set
   hpm_front #(
      .NUM_PAGES (NUM_PAGES),
      .NUM_SETS  (NUM_SETS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .init_busy  (init_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_page     (fq_page),
      .q_set      (fq_set),
      .q_last     (fq_last)
   );

   // decoupling queue, packed as last, set, page
   hpm_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  ({fq_last, fq_set, fq_page}),
      .pop_valid  (qe_valid),
      .pop_ready  (qe_pop),
      .pop_data   (qe_data)
   );

   // update engine: metadata read-modify-write, migration, decay sweep
   hpm_engine #(
      .NUM_PAGES (NUM_PAGES),
      .NUM_SETS  (NUM_SETS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .init_busy  (init_busy),
      .q_valid    (qe_valid),
      .q_pop      (qe_pop),
      .q_page     (qe_data[PW-1:0]),
      .q_set      (qe_data[PW+SW-1:PW]),
      .q_last     (qe_data[QW-1]),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/hpm_checker.sv */
module hpm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hpm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import hpm_pkg::*;

   logic               beat;
   logic [TALLY_W-1:0] total;
   logic [TALLY_W-1:0] sum_ff, sum_in;

   assign beat   = rsp_tvalid && rsp_tready;
   assign total  = rsp_tdata[46:15] + rsp_tdata[78:47];
   assign sum_in = beat ? total : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // a page already in fast memory never migrates
   a_hit_no_migrate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("migration reported on a fast hit");

   // evicted page only meaningful with a migration
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[13:2] == '0)
      else $error("evicted page without migration");

   // every result counts exactly one access
   a_tally_step: assert property (@(posedge clock) disable iff (reset)
      beat |-> total == sum_ff + TALLY_W'(1))
      else $error("hit and miss totals did not advance by one");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind hot_page_migration_direct_mapped hpm_checker u_hpm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
